// ----- src/relative_box_quantizer_macros.svh -----
// Assertion macros shared by the relative box quantizer RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef RELATIVE_BOX_QUANTIZER_MACROS_SVH
`define RELATIVE_BOX_QUANTIZER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rbq_pkg.sv -----
// Package of the relative box quantizer: widths, lane layout and types.
// Depends on nothing.
package rbq_pkg;
    localparam int NumAxes = 3;
    localparam int NumLanes = 6;
    localparam int QBits = 6;
    localparam int RemBits = 42;
    localparam int DiffBits = 35;
    localparam int ScaleXy = 31;
    localparam int ScaleZ = 63;

    typedef struct packed {
        logic [RemBits-1:0] rem;
        logic [QBits-1:0] q;
        logic neg;
        logic ovf;
    } lane_t;
endpackage

// ----- src/relative_box_quantizer.sv -----
// Relative box quantizer: one child box in, one packed 32-bit quantized box out.
// An accepted transaction passes through the difference, numerator, divider-setup, divider and output registers.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// The quotient comes from a six-stage restoring divider, one quotient bit per stage.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
// Depends on rbq_pkg and relative_box_quantizer_macros.svh.
`include "relative_box_quantizer_macros.svh"

module relative_box_quantizer
    import rbq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: ref_center_x/y/z (32 each), ref_half_x/y/z (31 each),
    // box_center_x/y/z (32 each), box_half_x/y/z (31 each), zero padding.
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: packed_box (32).
    output logic [31:0]  m_tdata
);

    logic en;
    logic [31:0] rc [NumAxes];
    logic [30:0] rh [NumAxes];
    logic [31:0] bc [NumAxes];
    logic [30:0] bh [NumAxes];

    logic signed [DiffBits-1:0] dmin_reg [NumAxes];
    logic signed [DiffBits-1:0] dmax_reg [NumAxes];
    logic [31:0] d1_reg [NumAxes];
    logic v1_reg;

    logic signed [RemBits-1:0] n_reg [NumLanes];
    logic [31:0] d2_reg [NumAxes];
    logic v2_reg;

    lane_t div_reg [QBits+1][NumLanes];
    logic [31:0] dd_reg [QBits+1][NumAxes];
    logic dv_reg [QBits+1];

    logic [31:0] pack_next;
    logic [31:0] out_reg;
    logic out_valid_reg;

    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    assign rc[0] = s_tdata[31:0];
    assign rc[1] = s_tdata[63:32];
    assign rc[2] = s_tdata[95:64];
    assign rh[0] = s_tdata[126:96];
    assign rh[1] = s_tdata[157:127];
    assign rh[2] = s_tdata[188:158];
    assign bc[0] = s_tdata[220:189];
    assign bc[1] = s_tdata[252:221];
    assign bc[2] = s_tdata[284:253];
    assign bh[0] = s_tdata[315:285];
    assign bh[1] = s_tdata[346:316];
    assign bh[2] = s_tdata[377:347];

    genvar a, l, s;
    generate
        for (a = 0; a < NumAxes; a++) begin : g_axis
            logic [30:0] rh_eff;
            logic signed [DiffBits-1:0] base;
            assign rh_eff = (rh[a] == '0) ? 31'd1 : rh[a];
            assign base = $signed({4'b0, rh_eff}) - $signed({{3{rc[a][31]}}, rc[a]})
                        + $signed({{3{bc[a][31]}}, bc[a]});

            always_ff @(posedge aclk) begin
                if (en) begin
                    dmin_reg[a] <= base - $signed({4'b0, bh[a]});
                    dmax_reg[a] <= base + $signed({4'b0, bh[a]});
                    d1_reg[a] <= {rh_eff, 1'b0};
                    d2_reg[a] <= d1_reg[a];
                    dd_reg[0][a] <= d2_reg[a];
                end
            end
        end

        for (l = 0; l < NumLanes; l++) begin : g_lane
            localparam int Ax = l % NumAxes;
            localparam bit IsMax = (l >= NumAxes);
            logic signed [RemBits-1:0] x;
            logic signed [RemBits-1:0] n_next;
            lane_t prep;
            assign x = IsMax ? RemBits'(dmax_reg[Ax]) : RemBits'(dmin_reg[Ax]);
            assign n_next = (Ax == 2) ? ((x <<< 6) - x) : ((x <<< 5) - x);

            always_comb begin
                if (IsMax) begin
                    prep.neg = n_reg[l][RemBits-1] || (n_reg[l] == '0);
                    prep.rem = n_reg[l] - RemBits'(1);
                end else begin
                    prep.neg = n_reg[l][RemBits-1];
                    prep.rem = n_reg[l];
                end
                prep.q = '0;
                prep.ovf = prep.rem >= {4'b0, d2_reg[Ax], 6'b0};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[l] <= n_next;
                    div_reg[0][l] <= prep;
                end
            end

            for (s = 0; s < QBits; s++) begin : g_div
                localparam int Bit = QBits - 1 - s;
                logic [RemBits-1:0] trial;
                lane_t step;
                assign trial = {10'b0, dd_reg[s][Ax]} << Bit;
                always_comb begin
                    step = div_reg[s][l];
                    if (div_reg[s][l].rem >= trial) begin
                        step.rem = div_reg[s][l].rem - trial;
                        step.q[Bit] = 1'b1;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en) begin
                        div_reg[s+1][l] <= step;
                    end
                end
            end
        end

        for (s = 0; s < QBits; s++) begin : g_dpipe
            always_ff @(posedge aclk) begin
                if (en) begin
                    dd_reg[s+1] <= dd_reg[s];
                end
            end
        end
    endgenerate

    always_comb begin
        logic [6:0] val;
        logic [6:0] lim;
        pack_next = '0;
        for (int i = 0; i < NumLanes; i++) begin
            lim = (i % NumAxes == 2) ? 7'(ScaleZ) : 7'(ScaleXy);
            val = {1'b0, div_reg[QBits][i].q} + ((i >= NumAxes) ? 7'd1 : 7'd0);
            if (div_reg[QBits][i].neg) begin
                val = '0;
            end else if (div_reg[QBits][i].ovf || val > lim) begin
                val = lim;
            end
            case (i)
                0: pack_next[4:0] = val[4:0];
                1: pack_next[9:5] = val[4:0];
                2: pack_next[15:10] = val[5:0];
                3: pack_next[20:16] = val[4:0];
                4: pack_next[25:21] = val[4:0];
                5: pack_next[31:26] = val[5:0];
                default: pack_next = pack_next;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= QBits; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int i = 0; i < QBits; i++) begin
                dv_reg[i+1] <= dv_reg[i];
            end
            out_valid_reg <= dv_reg[QBits];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= pack_next;
        end
    end

    `RBQ_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v1_reg,
        "accepted transaction did not enter the pipeline")
    `RBQ_ASSERT_NEXT(a_stall_holds, dv_reg[QBits] && !en, dv_reg[QBits],
        "stalled divider output was lost")
    `RBQ_ASSERT_NOW(a_rem_bound,
        dv_reg[QBits] && !div_reg[QBits][0].ovf && !div_reg[QBits][0].neg,
        div_reg[QBits][0].rem < {10'b0, dd_reg[QBits][0]},
        "divider remainder not below divisor")
    `RBQ_ASSERT_NEXT(a_out_from_div, dv_reg[QBits] && en, m_tvalid,
        "divider result did not reach the output")

endmodule
